FILE: design/skyatl_pkg.sv
// shared types, constants and helpers for the skyline atlas allocator
`default_nettype none

package skyatl_pkg;

  localparam int ATLAS_WIDTH  = 512;
  localparam int ATLAS_HEIGHT = 512;

  // field widths of the request and result
  localparam int WIDTH_W  = 9;
  localparam int HEIGHT_W = 10;
  localparam int POS_X_W  = 9;
  localparam int POS_Y_W  = 9;

  // column address and stored height widths
  localparam int ADDR_W = $clog2(ATLAS_WIDTH);
  localparam int FILL_W = $clog2(ATLAS_HEIGHT + 1);

  // widths for sums of addresses with widths, and heights with heights
  localparam int SUM_W  = ((ADDR_W > WIDTH_W) ? ADDR_W : WIDTH_W) + 1;
  localparam int HSUM_W = ((FILL_W > HEIGHT_W) ? FILL_W : HEIGHT_W) + 1;

  localparam logic [ADDR_W-1:0] LAST_COL = ADDR_W'(ATLAS_WIDTH - 2);
  localparam logic [ADDR_W-1:0] TOP_COL  = ADDR_W'(ATLAS_WIDTH - 1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FWD,
    ST_GAP,
    ST_BWD,
    ST_DRAIN,
    ST_DECIDE,
    ST_WRITE,
    ST_RESULT
  } state_t;

  // sequencer to datapath
  typedef struct packed {
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   pm_rd_addr;
    logic                fwd;
    logic                bwd;
    logic                blk_first;
    logic                eval;
    logic                start;
    logic                empty_win;
    logic                decide;
    logic [HEIGHT_W-1:0] rect_h;
    logic                wr_en;
    logic                wr_clear;
    logic [ADDR_W-1:0]   wr_addr;
    logic                res_load;
  } ctrl_t;

  // datapath result back to sequencer and output stage
  typedef struct packed {
    logic               granted;
    logic [POS_X_W-1:0] pos_x;
    logic [POS_Y_W-1:0] pos_y;
  } status_t;

  function automatic logic [FILL_W-1:0] fill_max(input logic [FILL_W-1:0] a,
                                                 input logic [FILL_W-1:0] b);
    fill_max = (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

FILE: design/skyatl_ctrl.sv
// sequencer: clearing sweep, forward and backward scan passes, write-back
`default_nettype none

module skyatl_ctrl (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [skyatl_pkg::WIDTH_W-1:0]   rect_width,
  input  wire logic [skyatl_pkg::HEIGHT_W-1:0]  rect_height,
  input  wire logic                             out_free,
  input  wire skyatl_pkg::status_t              status,
  output skyatl_pkg::ctrl_t                     ctrl
);

  skyatl_pkg::state_t state;
  skyatl_pkg::state_t state_next;

  logic [skyatl_pkg::ADDR_W-1:0]   idx;
  logic [skyatl_pkg::WIDTH_W-1:0]  phase;
  logic [skyatl_pkg::WIDTH_W-1:0]  wk;
  logic [skyatl_pkg::WIDTH_W-1:0]  w_reg;
  logic [skyatl_pkg::HEIGHT_W-1:0] h_reg;

  logic [skyatl_pkg::WIDTH_W-1:0]  w_less1;
  logic [skyatl_pkg::SUM_W-1:0]    win_end;
  logic [skyatl_pkg::SUM_W-1:0]    pm_addr_sum;
  logic [skyatl_pkg::SUM_W-1:0]    wr_addr_sum;
  logic                            too_wide;
  logic                            in_xfer;

  assign w_less1     = w_reg - skyatl_pkg::WIDTH_W'(1);
  assign win_end     = skyatl_pkg::SUM_W'(idx) + skyatl_pkg::SUM_W'(w_reg);
  assign pm_addr_sum = win_end - skyatl_pkg::SUM_W'(1);
  assign wr_addr_sum = skyatl_pkg::SUM_W'(status.pos_x) + skyatl_pkg::SUM_W'(wk);
  assign too_wide    = 32'(rect_width) >= skyatl_pkg::ATLAS_WIDTH;
  assign in_xfer     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skyatl_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    ctrl           = '0;
    ctrl.rd_addr   = idx;
    ctrl.pm_rd_addr = pm_addr_sum[skyatl_pkg::ADDR_W-1:0];
    ctrl.wr_addr   = idx;
    ctrl.rect_h    = h_reg;
    case (state)
      skyatl_pkg::ST_CLEAR: begin
        ctrl.wr_en    = 1'b1;
        ctrl.wr_clear = 1'b1;
        if (idx == skyatl_pkg::TOP_COL) begin
          state_next = skyatl_pkg::ST_IDLE;
        end
      end
      skyatl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.start     = 1'b1;
          ctrl.empty_win = (rect_width == '0);
          if (rect_width == '0 || too_wide) begin
            state_next = skyatl_pkg::ST_DECIDE;
          end else begin
            state_next = skyatl_pkg::ST_FWD;
          end
        end
      end
      skyatl_pkg::ST_FWD: begin
        ctrl.rd_en     = 1'b1;
        ctrl.fwd       = 1'b1;
        ctrl.blk_first = (phase == '0);
        if (idx == skyatl_pkg::LAST_COL) begin
          state_next = skyatl_pkg::ST_GAP;
        end
      end
      // lets the last prefix write land before the backward pass reads it
      skyatl_pkg::ST_GAP: begin
        state_next = skyatl_pkg::ST_BWD;
      end
      skyatl_pkg::ST_BWD: begin
        ctrl.rd_en     = 1'b1;
        ctrl.bwd       = 1'b1;
        ctrl.blk_first = (idx == skyatl_pkg::LAST_COL) || (phase == w_less1);
        ctrl.eval      = win_end <= skyatl_pkg::SUM_W'(skyatl_pkg::ATLAS_WIDTH - 1);
        if (idx == '0) begin
          state_next = skyatl_pkg::ST_DRAIN;
        end
      end
      skyatl_pkg::ST_DRAIN: begin
        state_next = skyatl_pkg::ST_DECIDE;
      end
      skyatl_pkg::ST_DECIDE: begin
        ctrl.decide = 1'b1;
        state_next  = skyatl_pkg::ST_WRITE;
      end
      skyatl_pkg::ST_WRITE: begin
        ctrl.wr_addr = wr_addr_sum[skyatl_pkg::ADDR_W-1:0];
        if (status.granted && wk != w_reg) begin
          ctrl.wr_en = 1'b1;
        end else begin
          state_next = skyatl_pkg::ST_RESULT;
        end
      end
      skyatl_pkg::ST_RESULT: begin
        if (out_free) begin
          ctrl.res_load = 1'b1;
          state_next    = skyatl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = skyatl_pkg::ST_IDLE;
      end
    endcase
  end

  // column index, block phase and write offset
  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      phase <= '0;
      wk    <= '0;
    end else begin
      case (state)
        skyatl_pkg::ST_CLEAR: begin
          idx <= idx + skyatl_pkg::ADDR_W'(1);
        end
        skyatl_pkg::ST_IDLE: begin
          idx   <= '0;
          phase <= '0;
        end
        skyatl_pkg::ST_FWD: begin
          // phase is kept at the last column for the backward pass
          if (idx != skyatl_pkg::LAST_COL) begin
            idx   <= idx + skyatl_pkg::ADDR_W'(1);
            phase <= (phase == w_less1) ? '0 : phase + skyatl_pkg::WIDTH_W'(1);
          end
        end
        skyatl_pkg::ST_BWD: begin
          if (idx != '0) begin
            idx   <= idx - skyatl_pkg::ADDR_W'(1);
            phase <= (phase == '0) ? w_less1 : phase - skyatl_pkg::WIDTH_W'(1);
          end
        end
        skyatl_pkg::ST_DECIDE: begin
          wk <= '0;
        end
        skyatl_pkg::ST_WRITE: begin
          if (status.granted && wk != w_reg) begin
            wk <= wk + skyatl_pkg::WIDTH_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      w_reg <= rect_width;
      h_reg <= rect_height;
    end
  end

endmodule

`default_nettype wire

FILE: design/skyatl_dpath.sv
// column memories, prefix/suffix window maximum unit and best-start tracking
`default_nettype none

module skyatl_dpath (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire skyatl_pkg::ctrl_t     ctrl,
  output skyatl_pkg::status_t        status
);

  logic [skyatl_pkg::FILL_W-1:0] fill_mem [skyatl_pkg::ATLAS_WIDTH];
  logic [skyatl_pkg::FILL_W-1:0] pm_mem   [skyatl_pkg::ATLAS_WIDTH];

  logic [skyatl_pkg::FILL_W-1:0] fill_rdata;
  logic [skyatl_pkg::FILL_W-1:0] pm_rdata;

  // read stage alignment
  logic                          fwd_d;
  logic                          bwd_d;
  logic                          first_d;
  logic                          eval_d;
  logic [skyatl_pkg::ADDR_W-1:0] addr_d;

  logic [skyatl_pkg::FILL_W-1:0] run;
  logic [skyatl_pkg::FILL_W-1:0] run_next;
  logic [skyatl_pkg::FILL_W-1:0] win_max;
  logic [skyatl_pkg::FILL_W-1:0] best;
  logic [skyatl_pkg::ADDR_W-1:0] bx;
  logic                          found;
  logic                          better;

  logic [skyatl_pkg::HSUM_W-1:0] top_sum;
  logic                          fits;
  logic [skyatl_pkg::FILL_W-1:0] new_h;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      fill_mem[ctrl.wr_addr] <= ctrl.wr_clear ? '0 : new_h;
    end
    if (ctrl.rd_en) begin
      fill_rdata <= fill_mem[ctrl.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (fwd_d) begin
      pm_mem[addr_d] <= run_next;
    end
    pm_rdata <= pm_mem[ctrl.pm_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_d  <= 1'b0;
      bwd_d  <= 1'b0;
      eval_d <= 1'b0;
    end else begin
      fwd_d  <= ctrl.fwd;
      bwd_d  <= ctrl.bwd;
      eval_d <= ctrl.eval;
    end
  end

  always_ff @(posedge clk) begin
    first_d <= ctrl.blk_first;
    addr_d  <= ctrl.rd_addr;
  end

  // running max restarts at each block edge: prefix forwards, suffix backwards
  assign run_next = first_d ? fill_rdata : skyatl_pkg::fill_max(run, fill_rdata);
  assign win_max  = skyatl_pkg::fill_max(run_next, pm_rdata);
  // scanning right to left, a tie moves the choice further left
  assign better   = (win_max < best) || (found && win_max == best);

  always_ff @(posedge clk) begin
    if (fwd_d || bwd_d) begin
      run <= run_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
      best  <= skyatl_pkg::FILL_W'(skyatl_pkg::ATLAS_HEIGHT);
      bx    <= '0;
    end else if (ctrl.start) begin
      found <= ctrl.empty_win;
      best  <= ctrl.empty_win ? '0 : skyatl_pkg::FILL_W'(skyatl_pkg::ATLAS_HEIGHT);
      bx    <= '0;
    end else if (bwd_d && eval_d && better) begin
      found <= 1'b1;
      best  <= win_max;
      bx    <= addr_d;
    end
  end

  assign top_sum = skyatl_pkg::HSUM_W'(best) + skyatl_pkg::HSUM_W'(ctrl.rect_h);
  assign fits    = found && (top_sum <= skyatl_pkg::HSUM_W'(skyatl_pkg::ATLAS_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      status.granted <= 1'b0;
    end else if (ctrl.decide) begin
      status.granted <= fits;
    end
    if (ctrl.decide) begin
      status.pos_x <= fits ? skyatl_pkg::POS_X_W'(bx) : '0;
      status.pos_y <= fits ? best[skyatl_pkg::POS_Y_W-1:0] : '0;
      new_h        <= top_sum[skyatl_pkg::FILL_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: design/skyline_atlas_allocator_core.sv
// after reset a sweep clears every column height; in_ready stays low meanwhile
// one request at a time: a forward and a backward pass over the column memory find the
// place, then the placed rectangle's columns are written back; a zero or oversize width
// skips both passes
// a finished result sits in the output register; the next request is taken while it waits,
// so a new request is taken only once the previous result has been loaded
`default_nettype none

module skyline_atlas_allocator_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [skyatl_pkg::WIDTH_W-1:0]   rect_width,
  input  wire logic [skyatl_pkg::HEIGHT_W-1:0]  rect_height,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  granted,
  output logic [skyatl_pkg::POS_X_W-1:0]        pos_x,
  output logic [skyatl_pkg::POS_Y_W-1:0]        pos_y
);

  skyatl_pkg::ctrl_t   ctrl;
  skyatl_pkg::status_t status;
  logic                out_free;

  assign out_free = !out_valid || out_ready;

  skyatl_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .out_free    (out_free),
    .status      (status),
    .ctrl        (ctrl)
  );

  skyatl_dpath u_dpath (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.res_load) begin
      granted <= status.granted;
      pos_x   <= status.pos_x;
      pos_y   <= status.pos_y;
    end
  end

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.res_load |-> out_free)
    else $error("result loaded while output register busy");

  // the block drops ready for the whole of a request
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready held after input transfer");

  // a refused request reports the origin
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !granted) |-> (pos_x == '0 && pos_y == '0))
    else $error("refused request with non-zero position");

  // memory writes and scan reads never overlap
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    ctrl.wr_en |-> !ctrl.rd_en)
    else $error("column write during scan read");

endmodule

`default_nettype wire

FILE: tb/skyline_check_pkg.sv
// scoreboard for the skyline atlas allocator: column heights and results still due
package skyline_check_pkg;

  import skyatl_pkg::*;

  class skyline_scoreboard;

    logic [FILL_W-1:0] col_height [ATLAS_WIDTH];
    status_t           due_results [$];
    int                mismatches;
    int                placed;
    int                refused;

    function new();
      foreach (col_height[i]) col_height[i] = '0;
      mismatches = 0;
      placed     = 0;
      refused    = 0;
    endfunction

    // work out where the rectangle lands and raise the skyline under it
    function void note_request(logic [WIDTH_W-1:0] w, logic [HEIGHT_W-1:0] h);
      int      best;
      int      bx;
      int      m;
      bit      found;
      status_t place;
      best  = ATLAS_HEIGHT;
      bx    = 0;
      found = 1'b0;
      // the scan stops one start short of the right edge
      for (int s = 0; s < ATLAS_WIDTH - int'(w); s++) begin
        m = 0;
        for (int j = 0; j < int'(w); j++)
          if (int'(col_height[s + j]) > m) m = int'(col_height[s + j]);
        if (m < best) begin
          best  = m;
          bx    = s;
          found = 1'b1;
        end
        // nothing can beat a floor of zero
        if (best == 0) break;
      end
      place = '0;
      if (found && best + int'(h) <= ATLAS_HEIGHT) begin
        for (int j = 0; j < int'(w); j++) col_height[bx + j] = FILL_W'(best + int'(h));
        place.granted = 1'b1;
        place.pos_x   = POS_X_W'(bx);
        place.pos_y   = POS_Y_W'(best);
      end
      due_results = {due_results, place};
    endfunction

    function void check_result(logic g, logic [POS_X_W-1:0] x, logic [POS_Y_W-1:0] y);
      status_t want;
      if (due_results.size() == 0) begin
        $error("result with no request outstanding: granted=%0d pos_x=%0d pos_y=%0d",
               g, x, y);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      if (g !== want.granted) begin
        $error("granted: expected %0d, got %0d", want.granted, g);
        mismatches++;
      end
      if (x !== want.pos_x) begin
        $error("pos_x: expected %0d, got %0d", want.pos_x, x);
        mismatches++;
      end
      if (y !== want.pos_y) begin
        $error("pos_y: expected %0d, got %0d", want.pos_y, y);
        mismatches++;
      end
      if (want.granted) placed++;
      else refused++;
    endfunction

    function int outstanding();
      return due_results.size();
    endfunction

  endclass

endpackage

FILE: tb/tb_skyline_atlas_allocator_core.sv
// top-level testbench for the skyline atlas allocator core
module tb_skyline_atlas_allocator_core;

  timeunit 1ns;
  timeprecision 1ps;

  import skyatl_pkg::*;
  import skyline_check_pkg::*;

  localparam int RANDOM_REQUESTS = 580;
  localparam int CYCLE_LIMIT     = 5_000_000;
  localparam int MAX_WAIT        = 18;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [WIDTH_W-1:0]  rect_width;
  logic [HEIGHT_W-1:0] rect_height;
  logic                out_valid;
  logic                out_ready;
  logic                granted;
  logic [POS_X_W-1:0]  pos_x;
  logic [POS_Y_W-1:0]  pos_y;

  skyline_scoreboard sb;
  int                cycles;
  int                requests_sent;
  bit                in_burst;
  bit                out_burst;

  skyline_atlas_allocator_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .granted     (granted),
    .pos_x       (pos_x),
    .pos_y       (pos_y)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $error("run timed out with %0d results still due", sb.outstanding());
      $display("TEST FAILED");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_request(input logic [WIDTH_W-1:0] w, input logic [HEIGHT_W-1:0] h);
    int gap;
    if ($urandom_range(0, 24) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    rect_width  <= w;
    rect_height <= h;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_request(w, h);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_request();
    int tier;
    int w;
    int h;
    tier = $urandom_range(0, 199);
    if (tier == 0) begin
      w = $urandom_range(0, 511);
      h = $urandom_range(0, 512);
    end else if (tier < 9) begin
      w = $urandom_range(201, 511);
      h = $urandom_range(1, 3);
    end else if (tier < 21) begin
      w = $urandom_range(1, 4);
      h = $urandom_range(13, 512);
    end else if (tier < 41) begin
      w = $urandom_range(25, 200);
      h = $urandom_range(1, 4);
    end else begin
      w = $urandom_range(1, 24);
      h = $urandom_range(1, 12);
    end
    send_request(WIDTH_W'(w), HEIGHT_W'(h));
  endtask

  // ready is dropped ahead of the result, held low once it shows up, or left high
  task automatic take_result();
    int stall;
    bit late;
    if ($urandom_range(0, 24) == 0) out_burst = !out_burst;
    stall = out_burst ? 0 : $urandom_range(0, MAX_WAIT);
    late  = !out_burst && ($urandom_range(0, 1) == 1);
    if (stall > 0 || late) out_ready <= 1'b0;
    if (late) begin
      do @(posedge clk); while (out_valid !== 1'b1);
      @(negedge clk);
    end
    repeat (stall) @(negedge clk);
    out_ready <= 1'b1;
    do @(posedge clk); while (out_valid !== 1'b1);
    sb.check_result(granted, pos_x, pos_y);
    @(negedge clk);
  endtask

  initial begin
    out_ready = 1'b0;
    out_burst = 1'b0;
    @(negedge rst);
    @(negedge clk);
    forever take_result();
  end

  initial begin
    sb            = new();
    rst           = 1'b1;
    in_valid      = 1'b0;
    rect_width    = '0;
    rect_height   = '0;
    requests_sent = 0;
    in_burst      = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero width: empty window granted at the origin, nothing written
    send_request(9'd0, 10'd7);
    // zero height: columns set to their window maximum
    send_request(9'd5, 10'd0);
    // fill column 0 to the top, then watch it being skipped
    send_request(9'd1, 10'd512);
    send_request(9'd1, 10'd1);
    // widest request: only start 0 is scanned, and it is full
    send_request(9'd511, 10'd1);
    send_request(9'd2, 10'd512);
    send_request(9'd510, 10'd1);
    send_request(9'd256, 10'd256);
    send_request(9'd300, 10'd100);
    send_request(9'd1, 10'd511);
    send_request(9'd511, 10'd512);
    send_request(9'd3, 10'd0);
    send_request(9'd0, 10'd0);
    send_request(9'd100, 10'd400);
    send_request(9'd1, 10'd1);
    send_request(9'd170, 10'd85);

    repeat (RANDOM_REQUESTS) send_random_request();
    in_valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    // room for a stray result after the last transfer
    repeat (1100) @(posedge clk);

    if (sb.outstanding() != 0) $error("%0d results never arrived", sb.outstanding());
    $display("%0d requests sent, 16 of them directed; %0d placed and %0d refused",
             requests_sent, sb.placed, sb.refused);
    $display("%0d field mismatches over %0d cycles", sb.mismatches, cycles);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
design/skyatl_pkg.sv
design/skyatl_ctrl.sv
design/skyatl_dpath.sv
design/skyline_atlas_allocator_core.sv
tb/skyline_check_pkg.sv
tb/tb_skyline_atlas_allocator_core.sv
